@@ hdl/spm_pkg.sv @@
// Package of the sparse polynomial multiplier: sizes, op codes, state type,
// and the command and status structs between controller and datapath.
// No dependencies.
package spm_pkg;

    // Store sizes
    localparam int MAX_TERMS         = 8;
    localparam int MAX_PRODUCT_TERMS = 64;

    // Index and count widths derived from the store sizes
    localparam int TERM_IW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
    localparam int TERM_CW = $clog2(MAX_TERMS + 1);
    localparam int PROD_IW = (MAX_PRODUCT_TERMS > 1) ? $clog2(MAX_PRODUCT_TERMS) : 1;
    localparam int PROD_CW = $clog2(MAX_PRODUCT_TERMS + 1);

    // Field widths
    localparam int OP_W       = 2;
    localparam int COEFF_IN_W = 16;
    localparam int EXP_IN_W   = 8;
    localparam int COEFF_W    = 32;
    localparam int EXP_W      = 9;
    localparam int PROD_W     = COEFF_W + EXP_W;

    // Operation codes of an input word
    localparam logic [OP_W-1:0] OP_LOAD_FIRST  = 2'd0;
    localparam logic [OP_W-1:0] OP_LOAD_SECOND = 2'd1;
    localparam logic [OP_W-1:0] OP_MULTIPLY    = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ROW,
        S_MERGE_RD,
        S_MERGE_CMP,
        S_ROW_END,
        S_EMIT_INIT,
        S_EMIT_RD,
        S_EMIT_LOAD,
        S_EMIT_WAIT
    } t_state;

    typedef struct packed {
        logic in_ready;
        logic load_first;
        logic load_second;
        logic start;
        logic row_step;
        logic merge_init;
        logic merge_step;
        logic row_end;
        logic emit_init;
        logic emit_load;
        logic emit_next;
        logic clear_ops;
    } t_cmd;

    typedef struct packed {
        logic ops_empty;
        logic row_more;
        logic merge_more;
        logic rows_last;
        logic out_take;
        logic out_last;
    } t_status;

endpackage

@@ hdl/spm_in_if.sv @@
// Input channel of the sparse polynomial multiplier: valid, ready and one
// load or multiply word. Depends on spm_pkg.
interface spm_in_if import spm_pkg::*; ();
    logic                         valid;
    logic                         ready;
    logic        [OP_W-1:0]       op;
    logic signed [COEFF_IN_W-1:0] coeff_in;
    logic        [EXP_IN_W-1:0]   exp_in;

    modport source (output valid, op, coeff_in, exp_in, input ready);
    modport sink   (input valid, op, coeff_in, exp_in, output ready);
endinterface

@@ hdl/spm_out_if.sv @@
// Result channel of the sparse polynomial multiplier: valid, ready and one
// product term word. Depends on spm_pkg.
interface spm_out_if import spm_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [COEFF_W-1:0] coeff_out;
    logic        [EXP_W-1:0]   exp_out;
    logic                      last;
    logic                      empty_res;

    modport source (output valid, coeff_out, exp_out, last, empty_res, input ready);
    modport sink   (input valid, coeff_out, exp_out, last, empty_res, output ready);
endinterface

@@ hdl/spm_ctrl.sv @@
// Controller of the sparse polynomial multiplier: sequences loads, row
// building, row merging and emission. Depends on spm_pkg.
module spm_ctrl import spm_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic [OP_W-1:0] i_op,
    input  t_status         i_status,
    output t_cmd            o_cmd
);

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid && (i_op == OP_MULTIPLY)) begin
                    n_state = i_status.ops_empty ? S_EMIT_INIT : S_ROW;
                end
            end
            S_ROW: begin
                if (!i_status.row_more) begin
                    n_state = S_MERGE_RD;
                end
            end
            S_MERGE_RD: begin
                n_state = i_status.merge_more ? S_MERGE_CMP : S_ROW_END;
            end
            S_MERGE_CMP: begin
                n_state = S_MERGE_RD;
            end
            S_ROW_END: begin
                n_state = i_status.rows_last ? S_EMIT_INIT : S_ROW;
            end
            S_EMIT_INIT: begin
                n_state = S_EMIT_RD;
            end
            S_EMIT_RD: begin
                n_state = S_EMIT_LOAD;
            end
            S_EMIT_LOAD: begin
                n_state = S_EMIT_WAIT;
            end
            S_EMIT_WAIT: begin
                if (i_status.out_take) begin
                    n_state = i_status.out_last ? S_IDLE : S_EMIT_RD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Command outputs
    always_comb begin
        o_cmd = '0;
        case (r_state)
            S_IDLE: begin
                o_cmd.in_ready    = 1'b1;
                o_cmd.load_first  = i_in_valid && (i_op == OP_LOAD_FIRST);
                o_cmd.load_second = i_in_valid && (i_op == OP_LOAD_SECOND);
                o_cmd.start       = i_in_valid && (i_op == OP_MULTIPLY);
            end
            S_ROW: begin
                o_cmd.row_step   = i_status.row_more;
                o_cmd.merge_init = !i_status.row_more;
            end
            S_MERGE_CMP: begin
                o_cmd.merge_step = 1'b1;
            end
            S_ROW_END: begin
                o_cmd.row_end = 1'b1;
            end
            S_EMIT_INIT: begin
                o_cmd.emit_init = 1'b1;
            end
            S_EMIT_LOAD: begin
                o_cmd.emit_load = 1'b1;
            end
            S_EMIT_WAIT: begin
                o_cmd.emit_next = i_status.out_take;
                o_cmd.clear_ops = i_status.out_take && i_status.out_last;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

@@ hdl/spm_dp.sv @@
// Datapath of the sparse polynomial multiplier: operand stores, row buffer
// with the shared multiplier, ping-pong product memory, merge unit and the
// output register. Depends on spm_pkg.
module spm_dp import spm_pkg::*; (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  t_cmd                         i_cmd,
    input  logic signed [COEFF_IN_W-1:0] i_coeff_in,
    input  logic        [EXP_IN_W-1:0]   i_exp_in,
    input  logic                         i_out_ready,
    output t_status                      o_status,
    output logic                         o_out_valid,
    output logic signed [COEFF_W-1:0]    o_coeff_out,
    output logic        [EXP_W-1:0]      o_exp_out,
    output logic                         o_last,
    output logic                         o_empty_res
);

    // Operand stores
    logic signed [COEFF_IN_W-1:0] r_first_c  [MAX_TERMS];
    logic        [EXP_IN_W-1:0]   r_first_e  [MAX_TERMS];
    logic signed [COEFF_IN_W-1:0] r_second_c [MAX_TERMS];
    logic        [EXP_IN_W-1:0]   r_second_e [MAX_TERMS];
    logic        [TERM_CW-1:0]    r_first_cnt;
    logic        [TERM_CW-1:0]    r_second_cnt;

    // Row buffer and its walk
    logic signed [COEFF_W-1:0] r_row_c [MAX_TERMS];
    logic        [EXP_W-1:0]   r_row_e [MAX_TERMS];
    logic        [TERM_CW-1:0] r_i;
    logic        [TERM_CW-1:0] r_j;
    logic        [TERM_CW-1:0] r_rn;
    logic        [TERM_CW-1:0] r_rj;

    // Product memory, two banks; r_bank selects the one holding the list
    logic [PROD_W-1:0]  r_mem0 [MAX_PRODUCT_TERMS];
    logic [PROD_W-1:0]  r_mem1 [MAX_PRODUCT_TERMS];
    logic [PROD_W-1:0]  r_rd0;
    logic [PROD_W-1:0]  r_rd1;
    logic               r_bank;
    logic [PROD_CW-1:0] r_pi;
    logic [PROD_CW-1:0] r_n;
    logic [PROD_CW-1:0] r_pcount;

    // Output register
    logic                      r_out_valid;
    logic signed [COEFF_W-1:0] r_out_c;
    logic        [EXP_W-1:0]   r_out_e;
    logic                      r_out_last;
    logic                      r_out_empty;

    logic signed [COEFF_W-1:0] w_prod;
    logic        [EXP_W-1:0]   w_prod_e;
    logic        [PROD_W-1:0]  w_src;
    logic signed [COEFF_W-1:0] w_pc;
    logic        [EXP_W-1:0]   w_pe;
    logic signed [COEFF_W-1:0] w_rc;
    logic        [EXP_W-1:0]   w_re;
    logic                      w_have_p;
    logic                      w_have_r;
    logic signed [COEFF_W:0]   w_sum;
    logic signed [COEFF_W-1:0] w_sat;
    logic signed [COEFF_W-1:0] w_mc;
    logic        [EXP_W-1:0]   w_me;
    logic                      w_take_p;
    logic                      w_take_r;
    logic                      w_wr;
    logic                      w_take;

    // One term pair of the row: product and exponent sum
    assign w_prod   = COEFF_W'(r_first_c[r_i[TERM_IW-1:0]])
                    * COEFF_W'(r_second_c[r_j[TERM_IW-1:0]]);
    assign w_prod_e = {1'b0, r_first_e[r_i[TERM_IW-1:0]]}
                    + {1'b0, r_second_e[r_j[TERM_IW-1:0]]};

    // Heads of the current product list and of the row
    assign w_src    = r_bank ? r_rd1 : r_rd0;
    assign w_pc     = w_src[PROD_W-1:EXP_W];
    assign w_pe     = w_src[EXP_W-1:0];
    assign w_rc     = r_row_c[r_rj[TERM_IW-1:0]];
    assign w_re     = r_row_e[r_rj[TERM_IW-1:0]];
    assign w_have_p = r_pi < r_pcount;
    assign w_have_r = r_rj < r_rn;

    // Saturating sum of two equal-exponent terms
    assign w_sum = {w_pc[COEFF_W-1], w_pc} + {w_rc[COEFF_W-1], w_rc};
    always_comb begin
        if (w_sum[COEFF_W] != w_sum[COEFF_W-1]) begin
            w_sat = w_sum[COEFF_W] ? {1'b1, {(COEFF_W-1){1'b0}}}
                                   : {1'b0, {(COEFF_W-1){1'b1}}};
        end else begin
            w_sat = w_sum[COEFF_W-1:0];
        end
    end

    // Merge choice: both heads, the product head, or the row head
    always_comb begin
        if (w_have_p && w_have_r && (w_pe == w_re)) begin
            w_mc     = w_sat;
            w_me     = w_pe;
            w_take_p = 1'b1;
            w_take_r = 1'b1;
        end else if (!w_have_r || (w_have_p && (w_pe > w_re))) begin
            w_mc     = w_pc;
            w_me     = w_pe;
            w_take_p = 1'b1;
            w_take_r = 1'b0;
        end else begin
            w_mc     = w_rc;
            w_me     = w_re;
            w_take_p = 1'b0;
            w_take_r = 1'b1;
        end
    end

    // Zero terms and terms past the store size are dropped
    assign w_wr = i_cmd.merge_step && (w_mc != '0)
                && (r_n < PROD_CW'(MAX_PRODUCT_TERMS));
    assign w_take = r_out_valid && i_out_ready;

    // Operand store contents
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_first && (r_first_cnt < TERM_CW'(MAX_TERMS))) begin
            r_first_c[r_first_cnt[TERM_IW-1:0]] <= i_coeff_in;
            r_first_e[r_first_cnt[TERM_IW-1:0]] <= i_exp_in;
        end
        if (i_cmd.load_second && (r_second_cnt < TERM_CW'(MAX_TERMS))) begin
            r_second_c[r_second_cnt[TERM_IW-1:0]] <= i_coeff_in;
            r_second_e[r_second_cnt[TERM_IW-1:0]] <= i_exp_in;
        end
        if (i_cmd.row_step && (w_prod != '0)) begin
            r_row_c[r_rn[TERM_IW-1:0]] <= w_prod;
            r_row_e[r_rn[TERM_IW-1:0]] <= w_prod_e;
        end
    end

    // Product memory: write the merged term into the other bank, read both
    always_ff @(posedge i_clk) begin
        if (w_wr && r_bank) begin
            r_mem0[r_n[PROD_IW-1:0]] <= {w_mc, w_me};
        end
        if (w_wr && !r_bank) begin
            r_mem1[r_n[PROD_IW-1:0]] <= {w_mc, w_me};
        end
        r_rd0 <= r_mem0[r_pi[PROD_IW-1:0]];
        r_rd1 <= r_mem1[r_pi[PROD_IW-1:0]];
    end

    // Counts and walk pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_cnt  <= '0;
            r_second_cnt <= '0;
            r_i          <= '0;
            r_j          <= '0;
            r_rn         <= '0;
            r_rj         <= '0;
            r_bank       <= 1'b0;
            r_pi         <= '0;
            r_n          <= '0;
            r_pcount     <= '0;
        end else begin
            if (i_cmd.load_first && (r_first_cnt < TERM_CW'(MAX_TERMS))) begin
                r_first_cnt <= r_first_cnt + TERM_CW'(1);
            end
            if (i_cmd.load_second && (r_second_cnt < TERM_CW'(MAX_TERMS))) begin
                r_second_cnt <= r_second_cnt + TERM_CW'(1);
            end
            if (i_cmd.start) begin
                r_i      <= '0;
                r_j      <= '0;
                r_rn     <= '0;
                r_pcount <= '0;
                r_bank   <= 1'b0;
            end
            if (i_cmd.row_step) begin
                r_j <= r_j + TERM_CW'(1);
                if (w_prod != '0) begin
                    r_rn <= r_rn + TERM_CW'(1);
                end
            end
            if (i_cmd.merge_init) begin
                r_pi <= '0;
                r_rj <= '0;
                r_n  <= '0;
            end
            if (i_cmd.merge_step) begin
                if (w_take_p) begin
                    r_pi <= r_pi + PROD_CW'(1);
                end
                if (w_take_r) begin
                    r_rj <= r_rj + TERM_CW'(1);
                end
                if (w_wr) begin
                    r_n <= r_n + PROD_CW'(1);
                end
            end
            if (i_cmd.row_end) begin
                r_bank   <= !r_bank;
                r_pcount <= r_n;
                r_i      <= r_i + TERM_CW'(1);
                r_j      <= '0;
                r_rn     <= '0;
            end
            if (i_cmd.emit_init) begin
                r_pi <= '0;
            end
            if (i_cmd.emit_next) begin
                r_pi <= r_pi + PROD_CW'(1);
            end
            if (i_cmd.clear_ops) begin
                r_first_cnt  <= '0;
                r_second_cnt <= '0;
                r_pcount     <= '0;
            end
        end
    end

    // Output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit_load) begin
            r_out_valid <= 1'b1;
        end else if (w_take) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output word; an empty product gives one marked zero word
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_load) begin
            if (r_pcount == '0) begin
                r_out_c     <= '0;
                r_out_e     <= '0;
                r_out_last  <= 1'b1;
                r_out_empty <= 1'b1;
            end else begin
                r_out_c     <= w_pc;
                r_out_e     <= w_pe;
                r_out_last  <= (r_pi + PROD_CW'(1)) == r_pcount;
                r_out_empty <= 1'b0;
            end
        end
    end

    // Status to the controller
    assign o_status.ops_empty  = (r_first_cnt == '0) || (r_second_cnt == '0);
    assign o_status.row_more   = r_j < r_second_cnt;
    assign o_status.merge_more = w_have_p || w_have_r;
    assign o_status.rows_last  = (r_i + TERM_CW'(1)) == r_first_cnt;
    assign o_status.out_take   = w_take;
    assign o_status.out_last   = r_out_last;

    assign o_out_valid = r_out_valid;
    assign o_coeff_out = r_out_c;
    assign o_exp_out   = r_out_e;
    assign o_last      = r_out_last;
    assign o_empty_res = r_out_empty;

endmodule

@@ hdl/sparse_polynomial_multiplier.sv @@
// Top level of the sparse polynomial multiplier: controller and datapath.
// Depends on spm_pkg, spm_in_if, spm_out_if, spm_ctrl and spm_dp.
//
// Words with op 0 and 1 load one term (signed coefficient, exponent, highest
// exponent first) of the first or second operand, one word per cycle; up to
// MAX_TERMS terms per operand are kept and further ones are dropped. A word
// with op 2 multiplies: for each first-operand term i, one shared 16x16
// multiplier builds the row of nonzero partial products over the N second
// terms, and the row is merged into the product list held in a ping-pong
// memory with a registered read port per bank, each merged term in a read
// state and then a compare state. The list, in descending exponent order
// with equal exponents summed and saturated to 32 bits and zero terms
// dropped, is then sent one word per term, each read only after the one
// before is taken, with last set on the final word; an empty product sends
// a single zero word with last and empty_res set. The input is not ready
// from the multiply word until the last result word is taken; op 3 is
// accepted and ignored. After the product is sent both operands are cleared.
module sparse_polynomial_multiplier import spm_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    spm_in_if.sink    i_in,
    spm_out_if.source o_res
);

    t_cmd    w_cmd;
    t_status w_status;

    spm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_op       (i_in.op),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    spm_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_coeff_in  (i_in.coeff_in),
        .i_exp_in    (i_in.exp_in),
        .i_out_ready (o_res.ready),
        .o_status    (w_status),
        .o_out_valid (o_res.valid),
        .o_coeff_out (o_res.coeff_out),
        .o_exp_out   (o_res.exp_out),
        .o_last      (o_res.last),
        .o_empty_res (o_res.empty_res)
    );

    assign i_in.ready = w_cmd.in_ready;

endmodule

@@ hdl/spm_chk.sv @@
// Port-level checker of the sparse polynomial multiplier and its bind to
// the top level. Depends on spm_pkg and sparse_polynomial_multiplier.
module spm_chk import spm_pkg::*; (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_in_ready,
    input logic                      i_out_valid,
    input logic                      i_out_ready,
    input logic signed [COEFF_W-1:0] i_coeff_out,
    input logic        [EXP_W-1:0]   i_exp_out,
    input logic                      i_last,
    input logic                      i_empty_res
);

    // Loads are never taken while a result word is pending.
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_in_ready && i_out_valid))
        else $error("input ready while a result word is pending");

    // Taking the last word of a product frees the input in the next cycle.
    a_last_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_ready && i_last) |=> i_in_ready)
        else $error("input not ready after the last result word");

    // The empty marker comes alone, as a zero word that closes the product.
    a_empty_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_empty_res) |->
            (i_last && (i_coeff_out == '0) && (i_exp_out == '0)))
        else $error("malformed empty product word");

    // A stalled result word holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable({i_coeff_out, i_exp_out, i_last, i_empty_res})))
        else $error("result word changed while stalled");

    // Reset leaves no result word pending.
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result word valid after reset");

endmodule

bind sparse_polynomial_multiplier spm_chk u_spm_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_coeff_out (o_res.coeff_out),
    .i_exp_out   (o_res.exp_out),
    .i_last      (o_res.last),
    .i_empty_res (o_res.empty_res)
);

@@ tb/tb_sparse_polynomial_multiplier.sv @@
// Testbench of the sparse polynomial multiplier: directed and random product jobs,
// each result word checked against a behavioral product predictor.
// Depends on spm_pkg, spm_in_if, spm_out_if and sparse_polynomial_multiplier.
module tb_sparse_polynomial_multiplier import spm_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    // The op code that the block accepts and ignores
    localparam logic [OP_W-1:0] OP_IGNORED = 2'd3;

    localparam int     CYCLE_LIMIT  = 1_000_000;
    localparam int     DRAIN_CYCLES = 40;
    localparam int     HOLD_CYCLES  = 600;
    localparam longint COEFF_MAX    = 64'sd2147483647;
    localparam longint COEFF_MIN    = -64'sd2147483648;

    typedef struct packed {
        logic signed [COEFF_W-1:0] coeff;
        logic        [EXP_W-1:0]   expo;
        logic                      last;
        logic                      empty;
    } t_product_term;

    logic i_clk;
    logic i_rst_n;

    spm_in_if  u_in_if ();
    spm_out_if u_res_if ();

    sparse_polynomial_multiplier u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (u_in_if),
        .o_res   (u_res_if)
    );

    // Predictor state: the two loaded operands
    logic signed [COEFF_IN_W-1:0] first_coeff  [MAX_TERMS];
    logic        [EXP_IN_W-1:0]   first_exp    [MAX_TERMS];
    int                           first_n;
    logic signed [COEFF_IN_W-1:0] second_coeff [MAX_TERMS];
    logic        [EXP_IN_W-1:0]   second_exp   [MAX_TERMS];
    int                           second_n;

    t_product_term expected_terms [$];
    t_product_term want_term;

    int  error_count;
    int  words_sent;
    int  cycle_count;
    int  send_idle_pct;
    int  recv_stall_pct;
    bit  hold_off;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string msg);
        $display("ERROR at %0t ns: %s", $time, msg);
        error_count++;
    endtask

    // Multiply the loaded operands row by row, merging each row into the
    // running product, and queue the result words that the block must send.
    function automatic void predict_product();
        longint        acc_c [MAX_PRODUCT_TERMS];
        int            acc_e [MAX_PRODUCT_TERMS];
        int            acc_n;
        longint        mrg_c [MAX_PRODUCT_TERMS];
        int            mrg_e [MAX_PRODUCT_TERMS];
        int            mrg_n;
        longint        row_c [MAX_TERMS];
        int            row_e [MAX_TERMS];
        int            row_n;
        longint        prod;
        longint        cand_c;
        int            cand_e;
        int            a;
        int            b;
        t_product_term term;

        acc_n = 0;
        if (first_n != 0 && second_n != 0) begin
            for (int i = 0; i < first_n; i++) begin
                // Nonzero partial products of one first-operand term
                row_n = 0;
                for (int j = 0; j < second_n; j++) begin
                    prod = longint'(first_coeff[i]) * longint'(second_coeff[j]);
                    if (prod != 0) begin
                        row_c[row_n] = prod;
                        row_e[row_n] = int'(first_exp[i]) + int'(second_exp[j]);
                        row_n++;
                    end
                end
                // Merge by descending exponent; sums saturate, zeros are dropped.
                a = 0;
                b = 0;
                mrg_n = 0;
                while (a < acc_n || b < row_n) begin
                    if (a < acc_n && b < row_n && acc_e[a] == row_e[b]) begin
                        cand_c = acc_c[a] + row_c[b];
                        if (cand_c > COEFF_MAX) begin
                            cand_c = COEFF_MAX;
                        end else if (cand_c < COEFF_MIN) begin
                            cand_c = COEFF_MIN;
                        end
                        cand_e = acc_e[a];
                        a++;
                        b++;
                    end else if (b >= row_n || (a < acc_n && acc_e[a] > row_e[b])) begin
                        cand_c = acc_c[a];
                        cand_e = acc_e[a];
                        a++;
                    end else begin
                        cand_c = row_c[b];
                        cand_e = row_e[b];
                        b++;
                    end
                    if (cand_c != 0 && mrg_n < MAX_PRODUCT_TERMS) begin
                        mrg_c[mrg_n] = cand_c;
                        mrg_e[mrg_n] = cand_e;
                        mrg_n++;
                    end
                end
                for (int k = 0; k < mrg_n; k++) begin
                    acc_c[k] = mrg_c[k];
                    acc_e[k] = mrg_e[k];
                end
                acc_n = mrg_n;
            end
        end

        first_n  = 0;
        second_n = 0;

        // An empty product is reported by a single flagged word.
        if (acc_n == 0) begin
            term.coeff = '0;
            term.expo  = '0;
            term.last  = 1'b1;
            term.empty = 1'b1;
            expected_terms.push_back(term);
        end else begin
            for (int k = 0; k < acc_n; k++) begin
                term.coeff = acc_c[k][COEFF_W-1:0];
                term.expo  = acc_e[k][EXP_W-1:0];
                term.last  = (k == acc_n - 1);
                term.empty = 1'b0;
                expected_terms.push_back(term);
            end
        end
    endfunction

    // Update the predictor with one accepted input word.
    function automatic void predict_word(input logic [OP_W-1:0] op,
                                         input logic signed [COEFF_IN_W-1:0] coeff,
                                         input logic [EXP_IN_W-1:0] expo);
        case (op)
            OP_LOAD_FIRST: begin
                if (first_n < MAX_TERMS) begin
                    first_coeff[first_n] = coeff;
                    first_exp[first_n]   = expo;
                    first_n++;
                end
            end
            OP_LOAD_SECOND: begin
                if (second_n < MAX_TERMS) begin
                    second_coeff[second_n] = coeff;
                    second_exp[second_n]   = expo;
                    second_n++;
                end
            end
            OP_MULTIPLY: begin
                predict_product();
            end
            default: begin
            end
        endcase
    endfunction

    // Offer one word after a random gap and wait until the block takes it.
    // Valid stays high on return so back-to-back words need no extra cycle.
    task automatic send_word(input logic [OP_W-1:0] op,
                             input logic signed [COEFF_IN_W-1:0] coeff,
                             input logic [EXP_IN_W-1:0] expo);
        while ($urandom_range(99) < send_idle_pct) begin
            u_in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        u_in_if.valid    <= 1'b1;
        u_in_if.op       <= op;
        u_in_if.coeff_in <= coeff;
        u_in_if.exp_in   <= expo;
        @(posedge i_clk);
        while (!u_in_if.ready) begin
            @(posedge i_clk);
        end
        predict_word(op, coeff, expo);
        if (op != OP_IGNORED) begin
            words_sent++;
        end
    endtask

    // Zero, the extremes, and otherwise any 16-bit value
    function automatic logic signed [COEFF_IN_W-1:0] pick_coeff();
        int roll;
        roll = $urandom_range(99);
        if (roll < 8) begin
            return '0;
        end else if (roll < 14) begin
            return 16'sh8000;
        end else if (roll < 20) begin
            return 16'sh7FFF;
        end
        return COEFF_IN_W'($urandom);
    endfunction

    // Term count of one operand: mostly small, sometimes empty or overfull
    function automatic int pick_count();
        int roll;
        roll = $urandom_range(99);
        if (roll < 5) begin
            return 0;
        end else if (roll < 12) begin
            return $urandom_range(MAX_TERMS + 2, MAX_TERMS + 1);
        end else if (roll < 30) begin
            return $urandom_range(MAX_TERMS, 5);
        end
        return $urandom_range(4, 1);
    endfunction

    // Next exponent: small descending steps so that products collide often
    function automatic int step_exp(input int prev, input bit scrambled);
        int next_e;
        if (scrambled) begin
            return $urandom_range(255);
        end
        next_e = prev - int'($urandom_range(6, 1));
        return (next_e < 0) ? int'($urandom_range(255)) : next_e;
    endfunction

    // One product job: interleaved loads of both operands, a few ignored
    // words, then the multiply word.
    task automatic send_product_job(input bit scrambled);
        int left_first;
        int left_second;
        int e_first;
        int e_second;
        left_first  = pick_count();
        left_second = pick_count();
        e_first     = $urandom_range(256, 30);
        e_second    = $urandom_range(256, 30);
        while (left_first > 0 || left_second > 0) begin
            if ($urandom_range(99) < 4) begin
                send_word(OP_IGNORED, COEFF_IN_W'($urandom), EXP_IN_W'($urandom));
            end
            if (left_second == 0 || (left_first > 0 && $urandom_range(1) == 0)) begin
                e_first = step_exp(e_first, scrambled);
                send_word(OP_LOAD_FIRST, pick_coeff(), e_first[7:0]);
                left_first--;
            end else begin
                e_second = step_exp(e_second, scrambled);
                send_word(OP_LOAD_SECOND, pick_coeff(), e_second[7:0]);
                left_second--;
            end
        end
        send_word(OP_MULTIPLY, COEFF_IN_W'($urandom), EXP_IN_W'($urandom));
    endtask

    // Both operands empty, then the first one empty: the flagged empty word each time.
    task automatic test_empty_products();
        send_word(OP_MULTIPLY, 16'sh0000, 8'h00);
        send_word(OP_LOAD_SECOND, 16'sh8000, 8'hFF);
        send_word(OP_MULTIPLY, 16'sh7FFF, 8'hFF);
    endtask

    // A single first term gives its row; the top exponents sum to 510, and an
    // ignored word in between changes nothing.
    task automatic test_single_term_first();
        send_word(OP_LOAD_FIRST, 16'sh7FFF, 8'hFF);
        send_word(OP_LOAD_SECOND, 16'sh8000, 8'hFF);
        send_word(OP_IGNORED, 16'sh8000, 8'h00);
        send_word(OP_LOAD_SECOND, 16'sh0001, 8'h00);
        send_word(OP_MULTIPLY, 16'sh0000, 8'h00);
    endtask

    // (0 x^200 + x + 1)(x - 1): zero products and a zero sum are dropped.
    task automatic test_cancellation();
        send_word(OP_LOAD_FIRST, 16'sh0000, 8'd200);
        send_word(OP_LOAD_FIRST, 16'sh0001, 8'd1);
        send_word(OP_LOAD_FIRST, 16'sh0001, 8'd0);
        send_word(OP_LOAD_SECOND, 16'sh0001, 8'd1);
        send_word(OP_LOAD_SECOND, 16'shFFFF, 8'd0);
        send_word(OP_MULTIPLY, 16'sh0000, 8'd0);
    endtask

    // Sums of extreme products clip at both ends of the 32-bit range.
    task automatic test_saturation();
        send_word(OP_LOAD_FIRST, 16'sh8000, 8'd1);
        send_word(OP_LOAD_FIRST, 16'sh8000, 8'd0);
        send_word(OP_LOAD_SECOND, 16'sh8000, 8'd1);
        send_word(OP_LOAD_SECOND, 16'sh8000, 8'd0);
        send_word(OP_MULTIPLY, 16'sh0000, 8'd0);
        for (int k = 2; k >= 0; k--) begin
            send_word(OP_LOAD_FIRST, 16'sh8000, 8'(k));
        end
        for (int k = 2; k >= 0; k--) begin
            send_word(OP_LOAD_SECOND, 16'sh7FFF, 8'(k));
        end
        send_word(OP_MULTIPLY, 16'sh0000, 8'd0);
    endtask

    // Random jobs under one idling profile; a few use unordered exponents.
    task automatic test_random_jobs(input int idle_pct, input int stall_pct,
                                    input int n_words);
        int target;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        target         = words_sent + n_words;
        while (words_sent < target) begin
            send_product_job($urandom_range(99) < 15);
        end
    endtask

    // The receiver holds off for a long stretch while jobs keep coming, so
    // the result side backs up and the input stops taking words.
    task automatic test_output_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        fork
            begin
                hold_off <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_off <= 1'b0;
            end
            begin
                repeat (4) send_product_job(1'b0);
            end
        join
    endtask

    // Result side: check each accepted word against the oldest expectation,
    // then pick the ready for the next cycle.
    always @(posedge i_clk) begin
        if (i_rst_n && u_res_if.valid && u_res_if.ready) begin
            if (expected_terms.size() == 0) begin
                report_mismatch($sformatf("unexpected word coeff %0d exp %0d last %b empty %b",
                    u_res_if.coeff_out, u_res_if.exp_out, u_res_if.last,
                    u_res_if.empty_res));
            end else begin
                want_term = expected_terms.pop_front();
                if (u_res_if.coeff_out !== want_term.coeff ||
                    u_res_if.exp_out !== want_term.expo ||
                    u_res_if.last !== want_term.last ||
                    u_res_if.empty_res !== want_term.empty) begin
                    report_mismatch($sformatf(
                        "got coeff %0d exp %0d last %b empty %b, want %0d %0d %b %b",
                        u_res_if.coeff_out, u_res_if.exp_out, u_res_if.last,
                        u_res_if.empty_res, want_term.coeff, want_term.expo,
                        want_term.last, want_term.empty));
                end
            end
        end
        u_res_if.ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
    end

    // Watchdog
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("sparse_polynomial_multiplier test failed");
        $finish;
    end

    initial begin
        i_rst_n          = 1'b0;
        u_in_if.valid    = 1'b0;
        u_in_if.op       = OP_LOAD_FIRST;
        u_in_if.coeff_in = '0;
        u_in_if.exp_in   = '0;
        hold_off         = 1'b0;
        error_count      = 0;
        words_sent       = 0;
        first_n          = 0;
        second_n         = 0;
        send_idle_pct    = 14;
        recv_stall_pct   = 67;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_products();
        test_single_term_first();
        test_cancellation();
        test_saturation();
        test_random_jobs(14, 67, 80);
        test_random_jobs(67, 14, 80);
        test_output_backpressure();
        test_random_jobs(0, 0, 80);

        // Let the last product drain, then allow for stray words.
        u_in_if.valid <= 1'b0;
        while (expected_terms.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (error_count == 0) begin
            $display("sparse_polynomial_multiplier test passed");
        end else begin
            $display("sparse_polynomial_multiplier test failed");
        end
        $finish;
    end

endmodule
